// ----- src/ldf_pkg.sv -----
package ldf_pkg;

   localparam int unsigned HEADER_BYTES = 8;
   localparam int unsigned HDR_CNT_W    = $clog2(HEADER_BYTES);
   localparam int unsigned LEN_W        = 8 * HEADER_BYTES;
   localparam int unsigned MAX_W        = 32;
   localparam int unsigned CSR_IDX_W    = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_LEN_LIMIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EMPTY_OK  = 2'd1;

   localparam logic [MAX_W-1:0] LEN_LIMIT_RST = 32'd65536;

   typedef enum logic [1:0] {
      KIND_BODY  = 2'd0,
      KIND_EMPTY = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE        = 3'd0,
      ERR_EMPTY       = 3'd1,
      ERR_TOO_LARGE   = 3'd2,
      ERR_HEADER_LINK = 3'd3,
      ERR_BODY_LINK   = 3'd4
   } err_type;

   typedef struct packed {
      logic [MAX_W-1:0] len_limit;
      logic             empty_ok;
   } cfg_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] body_byte;
      logic       last_of_frame;
      err_type    error_code;
   } rsp_type;

endpackage

// ----- src/ldf_core.sv -----
module ldf_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [7:0]       data_byte,
   input  logic             link_error,
   input  ldf_pkg::cfg_type cfg,
   output logic             res_valid,
   output ldf_pkg::rsp_type res
);

   typedef enum logic [1:0] {
      PH_HEADER = 2'b01,
      PH_BODY   = 2'b10
   } phase_type;

   phase_type                        phase_ff, phase_in;
   logic [ldf_pkg::HDR_CNT_W-1:0]    hdr_cnt_ff, hdr_cnt_in;
   logic [ldf_pkg::LEN_W-1:0]        len_acc_ff, len_acc_in;
   logic [ldf_pkg::MAX_W-1:0]        remain_ff, remain_in;
   logic                             stopped_ff, stopped_in;

   logic [ldf_pkg::LEN_W-1:0] hdr_len;
   logic                      hdr_done;
   logic                      len_zero;
   logic                      too_large;
   logic                      in_body;

   assign in_body   = (phase_ff == PH_BODY);
   assign hdr_len   = {len_acc_ff[ldf_pkg::LEN_W-9:0], data_byte};
   assign hdr_done  = (hdr_cnt_ff == ldf_pkg::HDR_CNT_W'(ldf_pkg::HEADER_BYTES - 1));
   assign len_zero  = (hdr_len == '0);
   assign too_large = (hdr_len[ldf_pkg::LEN_W-1:ldf_pkg::MAX_W] != '0) ||
                      (hdr_len[ldf_pkg::MAX_W-1:0] > cfg.len_limit);

   always_comb begin
      phase_in   = phase_ff;
      hdr_cnt_in = hdr_cnt_ff;
      len_acc_in = len_acc_ff;
      remain_in  = remain_ff;
      stopped_in = stopped_ff;
      res_valid  = 1'b0;
      res        = '{kind: ldf_pkg::KIND_BODY, body_byte: 8'd0, last_of_frame: 1'b0,
                     error_code: ldf_pkg::ERR_NONE};

      if (accept && !stopped_ff) begin
         if (link_error) begin
            // drop any partial header and stop for good
            res_valid      = 1'b1;
            res.kind       = ldf_pkg::KIND_ERROR;
            res.error_code = in_body ? ldf_pkg::ERR_BODY_LINK : ldf_pkg::ERR_HEADER_LINK;
            stopped_in     = 1'b1;
            phase_in       = PH_HEADER;
            hdr_cnt_in     = '0;
            len_acc_in     = '0;
            remain_in      = '0;
         end else if (in_body) begin
            res_valid         = 1'b1;
            res.body_byte     = data_byte;
            res.last_of_frame = (remain_ff == ldf_pkg::MAX_W'(1));
            remain_in         = remain_ff - ldf_pkg::MAX_W'(1);
            if (res.last_of_frame) begin
               phase_in = PH_HEADER;
            end
         end else if (!hdr_done) begin
            len_acc_in = hdr_len;
            hdr_cnt_in = hdr_cnt_ff + ldf_pkg::HDR_CNT_W'(1);
         end else begin
            hdr_cnt_in = '0;
            len_acc_in = '0;
            if (len_zero && !cfg.empty_ok) begin
               res_valid      = 1'b1;
               res.kind       = ldf_pkg::KIND_ERROR;
               res.error_code = ldf_pkg::ERR_EMPTY;
               stopped_in     = 1'b1;
               remain_in      = '0;
            end else if (too_large) begin
               res_valid      = 1'b1;
               res.kind       = ldf_pkg::KIND_ERROR;
               res.error_code = ldf_pkg::ERR_TOO_LARGE;
               stopped_in     = 1'b1;
               remain_in      = '0;
            end else if (len_zero) begin
               res_valid         = 1'b1;
               res.kind          = ldf_pkg::KIND_EMPTY;
               res.last_of_frame = 1'b1;
            end else begin
               phase_in  = PH_BODY;
               remain_in = hdr_len[ldf_pkg::MAX_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HEADER;
         hdr_cnt_ff <= '0;
         len_acc_ff <= '0;
         remain_ff  <= '0;
         stopped_ff <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         hdr_cnt_ff <= hdr_cnt_in;
         len_acc_ff <= len_acc_in;
         remain_ff  <= remain_in;
         stopped_ff <= stopped_in;
      end
   end

`ifndef SYNTHESIS
   a_stop_sticks: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |=> stopped_ff)
      else $error("stopped flag cleared without reset");

   a_body_nonzero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_BODY) |-> (remain_ff != '0 && hdr_cnt_ff == '0))
      else $error("body phase with no bytes remaining");

   a_stopped_idle: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |-> (!res_valid && phase_ff == PH_HEADER))
      else $error("stopped deframer still producing");
`endif

endmodule

// ----- src/length_prefixed_deframer_unit.sv -----
// Throughput: one input word per cycle while req_stall is low; header parse and
// body count share one pass. Result words are registered before rsp_* shows them.
// A two-entry output stage (register plus skid) absorbs one more result word while
// rsp_stall is high; req_stall is high only while the skid holds a word.
// Reset (synchronous, active high): header phase, counters cleared, running,
// output empty, length limit = 65536, empty frames refused.
module length_prefixed_deframer_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [7:0]                          req_data_byte,
   input  logic                                req_link_error,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_out_kind,
   output logic [7:0]                          rsp_body_byte,
   output logic                                rsp_last_of_frame,
   output logic [2:0]                          rsp_error_code,
   input  logic                                csr_wr_en,
   input  logic [ldf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ldf_pkg::MAX_W-1:0]           csr_wdata
);

   ldf_pkg::cfg_type cfg_ff;
   ldf_pkg::rsp_type res;
   logic             res_valid;
   logic             accept;
   logic             out_take;

   ldf_pkg::rsp_type out_ff, out_in, skid_ff, skid_in;
   logic             out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign out_take  = out_valid_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.len_limit <= ldf_pkg::LEN_LIMIT_RST;
         cfg_ff.empty_ok  <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            ldf_pkg::CSR_LEN_LIMIT: cfg_ff.len_limit <= csr_wdata;
            ldf_pkg::CSR_EMPTY_OK:  cfg_ff.empty_ok  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   ldf_core u_core (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .data_byte  (req_data_byte),
      .link_error (req_link_error),
      .cfg        (cfg_ff),
      .res_valid  (res_valid),
      .res        (res)
   );

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      // advance the skid word into the output register
      if (out_take) begin
         out_valid_in  = skid_valid_ff;
         out_in        = skid_ff;
         skid_valid_in = 1'b0;
      end
      if (res_valid) begin
         if (!out_valid_in) begin
            out_valid_in = 1'b1;
            out_in       = res;
         end else begin
            skid_valid_in = 1'b1;
            skid_in       = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_out_kind      = out_ff.kind;
   assign rsp_body_byte     = out_ff.body_byte;
   assign rsp_last_of_frame = out_ff.last_of_frame;
   assign rsp_error_code    = out_ff.error_code;

`ifndef SYNTHESIS
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid word held with empty output register");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (res_valid && skid_valid_ff) |-> 1'b0)
      else $error("result produced while skid is full");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !rsp_stall) |=> !skid_valid_ff)
      else $error("skid word not drained after output taken");
`endif

endmodule

// ----- bench/length_prefixed_deframer_unit_tb.sv -----
module length_prefixed_deframer_unit_tb;

   localparam int unsigned QUIET_LIMIT  = 2000;
   localparam int unsigned RANDOM_WORDS = 360;

   localparam logic [ldf_pkg::CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [ldf_pkg::CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   typedef enum logic [1:0] {
      PH_HEADER = 2'b01,
      PH_BODY   = 2'b10
   } phase_type;
   typedef enum logic {ROW_WORD, ROW_CSR} row_op_type;

   typedef struct {
      row_op_type                    op;
      logic [ldf_pkg::CSR_IDX_W-1:0] csr_idx;
      logic [ldf_pkg::MAX_W-1:0]     value;
      logic                          link_error;
      bit                            typed;
      ldf_pkg::rsp_type              want;
   } stim_row_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [7:0]                    req_data_byte = 8'h00;
   logic                          req_link_error = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [1:0]                    rsp_out_kind;
   logic [7:0]                    rsp_body_byte;
   logic                          rsp_last_of_frame;
   logic [2:0]                    rsp_error_code;
   logic                          csr_wr_en = 1'b0;
   logic [ldf_pkg::CSR_IDX_W-1:0] csr_index = ldf_pkg::CSR_LEN_LIMIT;
   logic [ldf_pkg::MAX_W-1:0]     csr_wdata = '0;

   // deframer shadow state
   logic [ldf_pkg::MAX_W-1:0] max_len_cfg = ldf_pkg::LEN_LIMIT_RST;
   logic                      allow_empty_cfg = 1'b0;
   phase_type                 phase = PH_HEADER;
   logic [2:0]                hdr_count = '0;
   logic [63:0]               len_acc = '0;
   logic [31:0]               remaining = '0;
   logic                      halted = 1'b0;

   ldf_pkg::rsp_type queued_words[$];
   stim_row_type     stim_table[$];
   int unsigned      mismatch_count = 0;
   int unsigned      words_sent = 0;
   int unsigned      quiet_cycles = 0;
   int unsigned      stall_left = 0;
   int unsigned      free_left = 0;
   bit               sender_dense = 1'b0;

   length_prefixed_deframer_unit DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_link_error    (req_link_error),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_kind      (rsp_out_kind),
      .rsp_body_byte     (rsp_body_byte),
      .rsp_last_of_frame (rsp_last_of_frame),
      .rsp_error_code    (rsp_error_code),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void clear_framing();
      phase = PH_HEADER;
      hdr_count = '0;
      len_acc = '0;
      remaining = '0;
   endfunction

   function automatic ldf_pkg::rsp_type halt_with(ldf_pkg::err_type code);
      halted = 1'b1;
      clear_framing();
      return '{ldf_pkg::KIND_ERROR, 8'h00, 1'b0, code};
   endfunction

   // Returns 1 when the word produces a result word.
   function automatic bit deframe_word(input logic [7:0] b, input logic le,
                                       output ldf_pkg::rsp_type r);
      logic [63:0] len;
      r = '{ldf_pkg::KIND_BODY, 8'h00, 1'b0, ldf_pkg::ERR_NONE};
      if (halted) return 1'b0;
      if (le) begin
         if (phase == PH_BODY) r = halt_with(ldf_pkg::ERR_BODY_LINK);
         else r = halt_with(ldf_pkg::ERR_HEADER_LINK);
         return 1'b1;
      end
      if (phase == PH_BODY) begin
         remaining = remaining - 32'd1;
         r.body_byte = b;
         if (remaining == 0) begin
            r.last_of_frame = 1'b1;
            clear_framing();
         end
         return 1'b1;
      end
      len_acc = {len_acc[55:0], b};
      hdr_count = hdr_count + 3'd1;
      if (hdr_count != 0) return 1'b0;
      len = len_acc;
      // empty check wins over the size check
      if (len == 0 && !allow_empty_cfg) begin
         r = halt_with(ldf_pkg::ERR_EMPTY);
         return 1'b1;
      end
      if (len > {32'd0, max_len_cfg}) begin
         r = halt_with(ldf_pkg::ERR_TOO_LARGE);
         return 1'b1;
      end
      if (len == 0) begin
         clear_framing();
         r = '{ldf_pkg::KIND_EMPTY, 8'h00, 1'b1, ldf_pkg::ERR_NONE};
         return 1'b1;
      end
      phase = PH_BODY;
      len_acc = '0;
      remaining = len[31:0];
      return 1'b0;
   endfunction

   function automatic logic [7:0] rand_byte();
      return 8'($urandom);
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Body length that the current settings accept.
   function automatic int unsigned pick_len();
      int unsigned lim;
      if (max_len_cfg == 0) return 0;
      if (allow_empty_cfg && $urandom_range(0, 7) == 0) return 0;
      lim = (max_len_cfg > 48) ? 48 : max_len_cfg;
      case ($urandom_range(0, 9))
         0: return lim;
         1, 2, 3: return $urandom_range(1, lim);
         default: return $urandom_range(1, (lim > 6) ? 6 : lim);
      endcase
   endfunction

   function automatic void add_word(logic [7:0] b, logic le = 1'b0, bit typed = 1'b0,
                                    ldf_pkg::rsp_type want = '0);
      stim_row_type row;
      row = '{ROW_WORD, ldf_pkg::CSR_LEN_LIMIT, {24'd0, b}, le, typed, want};
      stim_table.insert(stim_table.size(), row);
   endfunction

   function automatic void add_csr(logic [ldf_pkg::CSR_IDX_W-1:0] idx,
                                   logic [ldf_pkg::MAX_W-1:0] val);
      stim_row_type row;
      row = '{ROW_CSR, idx, val, 1'b0, 1'b0, '0};
      stim_table.insert(stim_table.size(), row);
   endfunction

   function automatic void add_header(logic [63:0] len, bit empty_typed = 1'b0);
      for (int k = 7; k > 0; k--) add_word(len[8*k +: 8]);
      add_word(len[7:0], 1'b0, empty_typed,
               '{ldf_pkg::KIND_EMPTY, 8'h00, 1'b1, ldf_pkg::ERR_NONE});
   endfunction

   task automatic send_word(input logic [7:0] b, input logic le, input bit typed = 1'b0,
                            input ldf_pkg::rsp_type want = '0);
      int unsigned      gap;
      ldf_pkg::rsp_type r;
      bit               hit;
      gap = sender_dense ? 0 : pick_gap();
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_link_error <= le;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      hit = deframe_word(b, le, r);
      if (typed) queued_words.insert(queued_words.size(), want);
      else if (hit) queued_words.insert(queued_words.size(), r);
      words_sent++;
   endtask

   task automatic send_header(input logic [63:0] len);
      for (int k = 7; k >= 0; k--) send_word(len[8*k +: 8], 1'b0);
   endtask

   // Hold the sender until every result word is back, then let the pipe empty.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (queued_words.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_csr(input logic [ldf_pkg::CSR_IDX_W-1:0] idx,
                            input logic [ldf_pkg::MAX_W-1:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      if (idx == ldf_pkg::CSR_LEN_LIMIT) max_len_cfg = val;
      else if (idx == ldf_pkg::CSR_EMPTY_OK) allow_empty_cfg = val[0];
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic reconfigure();
      logic [ldf_pkg::MAX_W-1:0] new_max;
      logic [ldf_pkg::MAX_W-1:0] flag_word;
      settle();
      case ($urandom_range(0, 5))
         0: new_max = '0;
         1: new_max = '1;
         2: new_max = $urandom_range(1, 12);
         3: new_max = ldf_pkg::LEN_LIMIT_RST;
         4: new_max = $urandom;
         default: new_max = $urandom_range(13, 48);
      endcase
      flag_word = $urandom;
      // a zero limit leaves only empty frames
      if (new_max == 0) flag_word[0] = 1'b1;
      if ($urandom_range(0, 1) == 0) begin
         write_csr(ldf_pkg::CSR_LEN_LIMIT, new_max);
         write_csr(ldf_pkg::CSR_EMPTY_OK, flag_word);
      end else begin
         write_csr(ldf_pkg::CSR_EMPTY_OK, flag_word);
         write_csr(ldf_pkg::CSR_LEN_LIMIT, new_max);
      end
      if ($urandom_range(0, 4) == 0)
         write_csr(($urandom_range(0, 1) == 0) ? CSR_SPARE_A : CSR_SPARE_B, $urandom);
   endtask

   task automatic send_frame();
      int unsigned len;
      len = pick_len();
      sender_dense = ($urandom_range(0, 3) == 0);
      send_header(64'(len));
      for (int unsigned i = 0; i < len; i++) begin
         // new settings must not touch the frame in flight
         if ($urandom_range(0, 59) == 0) reconfigure();
         send_word(rand_byte(), 1'b0);
      end
   endtask

   always @(negedge clock) begin
      if (free_left == 0 && stall_left == 0) begin
         stall_left = pick_gap();
         free_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 4);
      end
      if (free_left != 0) begin
         free_left--;
         rsp_stall <= 1'b0;
      end else begin
         stall_left--;
         rsp_stall <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_rsp
      ldf_pkg::rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (queued_words.size() == 0) begin
            $error("unexpected result word: out_kind %0d body_byte %0h",
                   rsp_out_kind, rsp_body_byte);
            mismatch_count++;
         end else begin
            want = queued_words.pop_front();
            if (rsp_out_kind !== want.kind) begin
               $error("out_kind: expected %0d, got %0d", want.kind, rsp_out_kind);
               mismatch_count++;
            end
            if (rsp_body_byte !== want.body_byte) begin
               $error("body_byte: expected %0h, got %0h", want.body_byte, rsp_body_byte);
               mismatch_count++;
            end
            if (rsp_last_of_frame !== want.last_of_frame) begin
               $error("last_of_frame: expected %0d, got %0d",
                      want.last_of_frame, rsp_last_of_frame);
               mismatch_count++;
            end
            if (rsp_error_code !== want.error_code) begin
               $error("error_code: expected %0d, got %0d", want.error_code, rsp_error_code);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("length_prefixed_deframer_unit_tb: errors");
         $finish;
      end
   end

   initial begin : stimulus
      ldf_pkg::err_type          ending;
      logic [63:0]               big_len;
      logic [ldf_pkg::MAX_W-1:0] hi_word;
      logic [ldf_pkg::MAX_W-1:0] lo_word;
      int unsigned               cut;
      int unsigned               len;

      // one-byte frame under the reset limit
      add_header(64'd1);
      add_word(8'hFF, 1'b0, 1'b1, '{ldf_pkg::KIND_BODY, 8'hFF, 1'b1, ldf_pkg::ERR_NONE});
      // empty frame passes even with a zero limit
      add_csr(ldf_pkg::CSR_EMPTY_OK, 32'hFFFF_FFFF);
      add_csr(ldf_pkg::CSR_LEN_LIMIT, 32'd0);
      add_csr(CSR_SPARE_A, 32'hFFFF_FFFF);
      add_header(64'd0, 1'b1);
      // length equal to the limit
      add_csr(ldf_pkg::CSR_LEN_LIMIT, 32'd2);
      add_header(64'd2);
      add_word(8'h00, 1'b0, 1'b1, '{ldf_pkg::KIND_BODY, 8'h00, 1'b0, ldf_pkg::ERR_NONE});
      add_word(8'h80);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (stim_table[i]) begin
         if (stim_table[i].op == ROW_CSR) begin
            settle();
            write_csr(stim_table[i].csr_idx, stim_table[i].value);
         end else begin
            send_word(stim_table[i].value[7:0], stim_table[i].link_error,
                      stim_table[i].typed, stim_table[i].want);
         end
      end

      while (words_sent < RANDOM_WORDS) begin
         if ($urandom_range(0, 5) == 0) reconfigure();
         else if ($urandom_range(0, 9) == 0) settle();
         send_frame();
      end

      // close with one fatal error; the block stays halted afterward
      sender_dense = 1'b0;
      ending = ldf_pkg::err_type'($urandom_range(ldf_pkg::ERR_EMPTY, ldf_pkg::ERR_BODY_LINK));
      case (ending)
         ldf_pkg::ERR_EMPTY: begin
            settle();
            lo_word = $urandom;
            lo_word[0] = 1'b0;
            write_csr(ldf_pkg::CSR_EMPTY_OK, lo_word);
            send_header(64'd0);
         end
         ldf_pkg::ERR_TOO_LARGE: begin
            if (max_len_cfg != '1 && $urandom_range(0, 1) == 0) begin
               big_len = {32'd0, max_len_cfg} + 64'd1;
            end else begin
               hi_word = $urandom_range(32'hFFFF_FFFF, 1);
               lo_word = $urandom;
               big_len = {hi_word, lo_word};
            end
            send_header(big_len);
         end
         ldf_pkg::ERR_HEADER_LINK: begin
            cut = $urandom_range(0, 7);
            repeat (cut) send_word(rand_byte(), 1'b0);
            send_word(rand_byte(), 1'b1);
         end
         default: begin
            if (max_len_cfg == 0) begin
               settle();
               write_csr(ldf_pkg::CSR_LEN_LIMIT, 32'd40);
            end
            do len = pick_len(); while (len == 0);
            send_header(64'(len));
            cut = $urandom_range(0, len - 1);
            repeat (cut) send_word(rand_byte(), 1'b0);
            send_word(rand_byte(), 1'b1);
         end
      endcase

      repeat (12) send_word(rand_byte(), 1'($urandom));

      settle();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && queued_words.size() == 0)
         $display("length_prefixed_deframer_unit_tb: clean");
      else
         $display("length_prefixed_deframer_unit_tb: errors");
      $finish;
   end

endmodule
